### hw/rtl/cpd_pkg.sv
// Command packet deframer: shared types and constants.
// Used by the front parser, job queue, back sequencer and top level.
package cpd_pkg;

   localparam int BYTE_W = 8;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_VERDICT = 2'd1;
   localparam logic [1:0] KIND_REPLY   = 2'd2;

   // verdict status
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_PKT_ERR     = 2'd1;
   localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

   // command index
   localparam logic [1:0] CMD_CALIBRATE     = 2'd0;
   localparam logic [1:0] CMD_ENABLE_BURST  = 2'd1;
   localparam logic [1:0] CMD_DISABLE_BURST = 2'd2;
   localparam logic [1:0] CMD_NONE          = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_SYNC          = 2'd0;
   localparam logic [1:0] CSR_CALIBRATE     = 2'd1;
   localparam logic [1:0] CSR_ENABLE_BURST  = 2'd2;
   localparam logic [1:0] CSR_DISABLE_BURST = 2'd3;

   // reset values of the registers
   localparam logic [BYTE_W-1:0] RST_SYNC          = 8'h00;
   localparam logic [BYTE_W-1:0] RST_CALIBRATE     = 8'h01;
   localparam logic [BYTE_W-1:0] RST_ENABLE_BURST  = 8'h02;
   localparam logic [BYTE_W-1:0] RST_DISABLE_BURST = 8'h03;

   localparam logic [BYTE_W-1:0] REPLY_LEN = 8'h01;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_value;
      logic [BYTE_W-1:0] calibrate_code;
      logic [BYTE_W-1:0] enable_burst_code;
      logic [BYTE_W-1:0] disable_burst_code;
   } cfg_type;

   typedef enum logic [1:0] {
      JOB_PAYLOAD = 2'd0,
      JOB_VERDICT = 2'd1,
      JOB_ERROR   = 2'd2
   } job_kind_type;

   // one unit of work for the back end; byte_value holds the command on errors
   typedef struct packed {
      job_kind_type      kind;
      logic [BYTE_W-1:0] byte_value;
      logic [1:0]        cmd_index;
      logic [1:0]        status;
      logic [BYTE_W-1:0] frame_len;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

### hw/rtl/cpd_ifs.sv
// Valid/ready channel interfaces of the command packet deframer.
// No dependencies.
interface cpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface cpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] byte_value;
   logic [1:0] cmd_index;
   logic [1:0] status;
   logic [7:0] frame_len;
   logic       last;

   modport source (output valid, output kind, output byte_value, output cmd_index,
                   output status, output frame_len, output last, input ready);
   modport sink (input valid, input kind, input byte_value, input cmd_index,
                 input status, input frame_len, input last, output ready);
endinterface

### hw/rtl/cpd_front.sv
// Front end: accepts received words, tracks frame fields, classifies bytes into jobs.
// Depends on cpd_pkg and cpd_req_if.
module cpd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  cpd_pkg::cfg_type      cfg,
   input  cpd_pkg::q_status_type q_status,
   output cpd_pkg::push_type     push,
   cpd_req_if.sink               req_if
);
   import cpd_pkg::*;

   typedef enum logic [4:0] {
      ST_SYNC    = 5'b00001,
      ST_CMD     = 5'b00010,
      ST_LEN     = 5'b00100,
      ST_PAYLOAD = 5'b01000,
      ST_CHECK   = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [BYTE_W-1:0] got_sync_ff, got_sync_in;
   logic [BYTE_W-1:0] frame_cmd_ff, frame_cmd_in;
   logic [BYTE_W-1:0] frame_len_ff, frame_len_in;
   logic [BYTE_W-1:0] bytes_left_ff, bytes_left_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic              accept;
   logic [BYTE_W-1:0] b;

   assign req_if.ready = !q_status.full;
   assign accept       = req_if.valid && req_if.ready;
   assign b            = req_if.rx_byte;

   always_comb begin
      state_in      = state_ff;
      got_sync_in   = got_sync_ff;
      frame_cmd_in  = frame_cmd_ff;
      frame_len_in  = frame_len_ff;
      bytes_left_in = bytes_left_ff;
      xor_in        = xor_ff;
      push.valid           = 1'b0;
      push.job.kind        = JOB_PAYLOAD;
      push.job.byte_value  = b;
      push.job.cmd_index   = CMD_NONE;
      push.job.status      = STATUS_OK;
      push.job.frame_len   = frame_len_ff;
      if (accept) begin
         case (state_ff)
            ST_CMD: begin
               frame_cmd_in = b;
               xor_in       = b;
               state_in     = ST_LEN;
            end
            ST_LEN: begin
               frame_len_in  = b;
               xor_in        = xor_ff ^ b;
               bytes_left_in = b;
               state_in      = (b == '0) ? ST_CHECK : ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
               xor_in        = xor_ff ^ b;
               push.valid    = 1'b1;
               bytes_left_in = bytes_left_ff - 8'd1;
               if (bytes_left_ff == 8'd1) begin
                  state_in = ST_CHECK;
               end
            end
            ST_CHECK: begin
               push.valid          = 1'b1;
               push.job.kind       = JOB_VERDICT;
               push.job.byte_value = frame_cmd_ff;
               if (got_sync_ff != cfg.sync_value || b != xor_ff) begin
                  push.job.kind   = JOB_ERROR;
                  push.job.status = STATUS_PKT_ERR;
               end else if (frame_cmd_ff == cfg.calibrate_code) begin
                  push.job.cmd_index = CMD_CALIBRATE;
               end else if (frame_cmd_ff == cfg.enable_burst_code) begin
                  push.job.cmd_index = CMD_ENABLE_BURST;
               end else if (frame_cmd_ff == cfg.disable_burst_code) begin
                  push.job.cmd_index = CMD_DISABLE_BURST;
               end else begin
                  push.job.status = STATUS_UNSUPPORTED;
               end
               state_in = ST_SYNC;
            end
            default: begin
               got_sync_in = b;
               state_in    = ST_CMD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SYNC;
         got_sync_ff   <= '0;
         frame_cmd_ff  <= '0;
         frame_len_ff  <= '0;
         bytes_left_ff <= '0;
         xor_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         got_sync_ff   <= got_sync_in;
         frame_cmd_ff  <= frame_cmd_in;
         frame_len_ff  <= frame_len_in;
         bytes_left_ff <= bytes_left_in;
         xor_ff        <= xor_in;
      end
   end

   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAYLOAD |-> bytes_left_ff != '0)
      else $error("payload state with no bytes left");

   a_push_accept: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> accept)
      else $error("job pushed without an accepted word");

   a_check_after: assert property (@(posedge clock) disable iff (reset)
      accept && state_ff == ST_CHECK |=> state_ff == ST_SYNC)
      else $error("frame end did not return to sync");

endmodule

### hw/rtl/cpd_queue.sv
// Job queue between front end and back end.
// Depends on cpd_pkg.
module cpd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cpd_pkg::push_type     push,
   input  logic                  pop,
   output cpd_pkg::job_type      head,
   output cpd_pkg::q_status_type status
);
   import cpd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign head         = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push.valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !status.full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count out of range");

endmodule

### hw/rtl/cpd_back.sv
// Back end: expands jobs into result words, including the error reply frame.
// Depends on cpd_pkg and cpd_rsp_if.
module cpd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  cpd_pkg::cfg_type      cfg,
   input  cpd_pkg::job_type      head,
   input  cpd_pkg::q_status_type q_status,
   output logic                  pop,
   cpd_rsp_if.source             rsp_if
);
   import cpd_pkg::*;

   localparam logic [2:0] STEP_SYNC   = 3'd1;
   localparam logic [2:0] STEP_CMD    = 3'd2;
   localparam logic [2:0] STEP_LEN    = 3'd3;
   localparam logic [2:0] STEP_STATUS = 3'd4;
   localparam logic [2:0] STEP_CHECK  = 3'd5;

   logic              busy_ff, busy_in;
   logic [2:0]        step_ff, step_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic              valid_ff, valid_in;
   logic [1:0]        kind_ff, kind_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [1:0]        idx_ff, idx_in;
   logic [1:0]        status_ff, status_in;
   logic [BYTE_W-1:0] flen_ff, flen_in;
   logic              last_ff, last_in;
   logic              load;
   logic [BYTE_W-1:0] reply_ck;

   assign load     = !valid_ff || rsp_if.ready;
   assign pop      = load && !busy_ff && !q_status.empty;
   assign reply_ck = cmd_ff ^ REPLY_LEN ^ {6'd0, STATUS_PKT_ERR};

   always_comb begin
      busy_in   = busy_ff;
      step_in   = step_ff;
      cmd_in    = cmd_ff;
      len_in    = len_ff;
      valid_in  = valid_ff;
      kind_in   = kind_ff;
      byte_in   = byte_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      flen_in   = flen_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in = busy_ff || !q_status.empty;
         if (busy_ff) begin
            kind_in   = KIND_REPLY;
            idx_in    = CMD_NONE;
            status_in = STATUS_OK;
            flen_in   = len_ff;
            last_in   = (step_ff == STEP_CHECK);
            step_in   = step_ff + 3'd1;
            busy_in   = (step_ff != STEP_CHECK);
            case (step_ff)
               STEP_SYNC:   byte_in = cfg.sync_value;
               STEP_CMD:    byte_in = cmd_ff;
               STEP_LEN:    byte_in = REPLY_LEN;
               STEP_STATUS: byte_in = {6'd0, STATUS_PKT_ERR};
               default:     byte_in = reply_ck;
            endcase
         end else if (!q_status.empty) begin
            idx_in    = head.cmd_index;
            status_in = head.status;
            flen_in   = head.frame_len;
            case (head.kind)
               JOB_PAYLOAD: begin
                  kind_in = KIND_PAYLOAD;
                  byte_in = head.byte_value;
                  last_in = 1'b1;
               end
               JOB_ERROR: begin
                  kind_in = KIND_VERDICT;
                  byte_in = '0;
                  last_in = 1'b0;
                  busy_in = 1'b1;
                  step_in = STEP_SYNC;
                  cmd_in  = head.byte_value;
                  len_in  = head.frame_len;
               end
               default: begin
                  kind_in = KIND_VERDICT;
                  byte_in = '0;
                  last_in = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      len_ff    <= len_in;
      kind_ff   <= kind_in;
      byte_ff   <= byte_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      flen_ff   <= flen_in;
      last_ff   <= last_in;
   end

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.kind       = kind_ff;
   assign rsp_if.byte_value = byte_ff;
   assign rsp_if.cmd_index  = idx_ff;
   assign rsp_if.status     = status_ff;
   assign rsp_if.frame_len  = flen_ff;
   assign rsp_if.last       = last_ff;

   a_busy_no_pop: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !pop)
      else $error("job popped during reply frame");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff >= STEP_SYNC && step_ff <= STEP_CHECK)
      else $error("reply step out of range");

   a_error_verdict_not_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == KIND_VERDICT && status_ff == STATUS_PKT_ERR |-> !last_ff && busy_ff)
      else $error("error verdict without reply frame");

   a_reply_busy: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == KIND_REPLY && !last_ff |-> busy_ff)
      else $error("reply frame cut short");

endmodule

### hw/rtl/command_packet_deframer.sv
// Command packet deframer top level: registers, front end, job queue, back end.
// Throughput: one input word per cycle while the job queue is not full, and one result
// word per cycle while rsp_if.ready is high; an error frame yields 6 result words,
// absorbed by the QUEUE_DEPTH-entry job queue.
// Reset: synchronous, active high; parser returns to sync wait, registers to defaults.
// Depends on cpd_pkg, cpd_ifs, cpd_front, cpd_queue, cpd_back.
module command_packet_deframer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data,
   cpd_req_if.sink    req_if,
   cpd_rsp_if.source  rsp_if
);
   import cpd_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   push_type     push;
   job_type      head;
   q_status_type q_status;
   logic         pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SYNC:          cfg_in.sync_value         = csr_write_data;
            CSR_CALIBRATE:     cfg_in.calibrate_code     = csr_write_data;
            CSR_ENABLE_BURST:  cfg_in.enable_burst_code  = csr_write_data;
            CSR_DISABLE_BURST: cfg_in.disable_burst_code = csr_write_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_value         <= RST_SYNC;
         cfg_ff.calibrate_code     <= RST_CALIBRATE;
         cfg_ff.enable_burst_code  <= RST_ENABLE_BURST;
         cfg_ff.disable_burst_code <= RST_DISABLE_BURST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cpd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_status (q_status),
      .push     (push),
      .req_if   (req_if)
   );

   cpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   cpd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

endmodule
